### sv/rk4_four_compartment_step_assert.svh
// Assertion macros used by the integrator controller.
`ifndef RK4_FOUR_COMPARTMENT_STEP_ASSERT_SVH
`define RK4_FOUR_COMPARTMENT_STEP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RK4_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the condition.
`define RK4_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`endif

### sv/rk4_pkg.sv
// ----------------------------------------------------------------------------
// rk4_pkg
// Shared types and constants of the four-compartment RK4 integrator.
// ----------------------------------------------------------------------------
`default_nettype none
package rk4_pkg;
  localparam int unsigned QSHIFT = 24;
  localparam logic signed [31:0] H_FULL = 32'sd167772;
  localparam logic signed [31:0] H_HALF = 32'sd83886;
  localparam logic signed [31:0] H_SIXTH = 32'sd27962;
  localparam logic [19:0] STEP_MAX = 20'hFFFFF;

  localparam logic [2:0] CFG_G = 3'd0;
  localparam logic [2:0] CFG_GS = 3'd1;
  localparam logic [2:0] CFG_AG = 3'd2;
  localparam logic [2:0] CFG_ALFA = 3'd3;
  localparam logic [2:0] CFG_BETA = 3'd4;
  localparam logic [2:0] CFG_STEPS = 3'd5;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_RUN, ST_DONE
  } rk4_state_e;

  // Controller commands to the datapath.
  typedef struct packed {
    logic start_div;  // load counts and start the serial divider
    logic start_rk;   // start the RK4 sequence
    logic commit;     // write results back to state
  } rk4_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic div_done;
    logic rk_done;
    logic zero_sum;
  } rk4_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

### sv/rk4_four_compartment_step.sv
// ----------------------------------------------------------------------------
// rk4_four_compartment_step
// Four-compartment population model, one RK4 step (h = 0.01) per step item.
// ----------------------------------------------------------------------------
// A start item runs the serial divider, which produces one quotient bit per
// cycle for each of the four fractions in turn. A step item runs four RK4
// stages of fifteen slots on one shared multiplier. One item is worked on at
// a time; the result waits in the output registers until it is taken.
`default_nettype none
module rk4_four_compartment_step #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [19:0] cfg_data_i,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic req_type_i,
  input  wire logic [COUNT_BITS-1:0] count_reactionary_pool_i,
  input  wire logic [COUNT_BITS-1:0] count_people_pool_i,
  input  wire logic [COUNT_BITS-1:0] count_revolutionaries_i,
  input  wire logic [COUNT_BITS-1:0] count_active_reactionaries_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output logic [FRAC_BITS:0] frac_reactionary_pool_o,
  output logic [FRAC_BITS:0] frac_people_pool_o,
  output logic [FRAC_BITS:0] frac_revolutionaries_o,
  output logic [FRAC_BITS:0] frac_active_reactionaries_o,
  output logic [19:0] step_index_o,
  output logic run_done_o,
  output logic status_o
);
  import rk4_pkg::*;
  rk4_cmd_t cmd;
  rk4_sts_t sts;
  logic [COUNT_BITS-1:0] cnt [4];
  logic [FRAC_BITS:0] frac [4];

  assign cnt[0] = count_reactionary_pool_i;
  assign cnt[1] = count_people_pool_i;
  assign cnt[2] = count_revolutionaries_i;
  assign cnt[3] = count_active_reactionaries_i;

  rk4_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i,
    .out_valid_o, .out_ready_i, .cmd_o(cmd), .sts_i(sts)
  );

  rk4_datapath #(.FRAC_BITS(FRAC_BITS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cnt_i(cnt),
    .cmd_i(cmd), .sts_o(sts), .frac_o(frac), .step_index_o, .run_done_o,
    .status_o
  );

  assign frac_reactionary_pool_o = frac[0];
  assign frac_people_pool_o = frac[1];
  assign frac_revolutionaries_o = frac[2];
  assign frac_active_reactionaries_o = frac[3];
endmodule
`default_nettype wire

### sv/rk4_ctrl.sv
// ----------------------------------------------------------------------------
// rk4_ctrl
// Request sequencer: accepts items, drives the datapath, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rk4_four_compartment_step_assert.svh"
module rk4_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic req_type_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output rk4_pkg::rk4_cmd_t cmd_o,
  input  wire rk4_pkg::rk4_sts_t sts_i
);
  import rk4_pkg::*;
  rk4_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (req_type_i == REQ_START) begin
            cmd_o.start_div = 1'b1;
            state_d = ST_DIV;
          end else begin
            cmd_o.start_rk = 1'b1;
            state_d = ST_RUN;
          end
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.commit = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_RUN: begin
        if (sts_i.rk_done) begin
          cmd_o.commit = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `RK4_ASSERT_NEXT(a_commit_shows, clk_i, rst_ni, cmd_o.commit, out_valid_o, "commit without result")
  `RK4_ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, out_valid_o, !in_ready_o, "accept while result held")
  `RK4_ASSERT_IMPL(a_one_cmd, clk_i, rst_ni, 1'b1, $onehot0(cmd_o), "several commands at once")
endmodule
`default_nettype wire

### sv/rk4_datapath.sv
// ----------------------------------------------------------------------------
// rk4_datapath
// State, configuration, serial divider and shared multiplier datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module rk4_datapath #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [19:0] cfg_data_i,
  input  wire logic [COUNT_BITS-1:0] cnt_i [4],
  input  wire rk4_pkg::rk4_cmd_t cmd_i,
  output rk4_pkg::rk4_sts_t sts_o,
  output logic [FRAC_BITS:0] frac_o [4],
  output logic [19:0] step_index_o,
  output logic run_done_o,
  output logic status_o
);
  import rk4_pkg::*;
  localparam int unsigned SUMW = COUNT_BITS + 2;
  localparam int unsigned NUMW = COUNT_BITS + FRAC_BITS;
  localparam int unsigned DCW = $clog2(NUMW + 1);
  localparam int unsigned FSH = QSHIFT - FRAC_BITS;

  logic [15:0] coef_q [5];
  logic [19:0] steps_q;
  logic [FRAC_BITS:0] frac_q [4];
  logic [FRAC_BITS:0] cap_r_q, cap_p_q;
  logic [19:0] step_q;
  logic run_done_q, status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= 16'd1638; coef_q[1] <= 16'd1638; coef_q[2] <= 16'd2458;
      coef_q[3] <= 16'd2458; coef_q[4] <= 16'd1638; steps_q <= 20'd10000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_G: coef_q[0] <= cfg_data_i[15:0];
        CFG_GS: coef_q[1] <= cfg_data_i[15:0];
        CFG_AG: coef_q[2] <= cfg_data_i[15:0];
        CFG_ALFA: coef_q[3] <= cfg_data_i[15:0];
        CFG_BETA: coef_q[4] <= cfg_data_i[15:0];
        CFG_STEPS: steps_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- serial divider: one quotient bit per cycle, lane by lane
  logic [COUNT_BITS-1:0] cnt_q [4];
  logic [SUMW-1:0] sum_q;
  logic [1:0] lane_q;
  logic [DCW-1:0] bit_q;
  logic [SUMW:0] rem_q;
  logic [NUMW-1:0] num_q;
  logic [FRAC_BITS:0] quo_q [4];
  logic div_busy_q, div_done_q, zero_q;
  logic [SUMW:0] rem_sh;
  logic qbit;

  assign rem_sh = {rem_q[SUMW-1:0], num_q[NUMW-1]};
  assign qbit = rem_sh >= {1'b0, sum_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0; div_done_q <= 1'b0; zero_q <= 1'b0;
      lane_q <= '0; bit_q <= '0;
    end else begin
      div_done_q <= 1'b0;
      if (cmd_i.start_div) begin
        zero_q <= ({2'b0, cnt_i[0]} + {2'b0, cnt_i[1]} + {2'b0, cnt_i[2]}
                   + {2'b0, cnt_i[3]}) == '0;
        div_busy_q <= 1'b1; lane_q <= '0; bit_q <= '0;
      end else if (div_busy_q) begin
        if (bit_q == DCW'(NUMW - 1)) begin
          bit_q <= '0;
          lane_q <= lane_q + 2'd1;
          if (lane_q == 2'd3) begin
            div_busy_q <= 1'b0; div_done_q <= 1'b1;
          end
        end else bit_q <= bit_q + DCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_div) begin
      for (int i = 0; i < 4; i++) cnt_q[i] <= cnt_i[i];
      sum_q <= {2'b0, cnt_i[0]} + {2'b0, cnt_i[1]} + {2'b0, cnt_i[2]} + {2'b0, cnt_i[3]};
      num_q <= {cnt_i[0], {FRAC_BITS{1'b0}}};
      rem_q <= '0;
    end else if (div_busy_q) begin
      if (bit_q == DCW'(NUMW - 1)) begin
        quo_q[lane_q] <= (FRAC_BITS+1)'({num_q[NUMW-2:0], qbit});
        rem_q <= '0;
        if (lane_q != 2'd3) num_q <= {cnt_q[lane_q + 2'd1], {FRAC_BITS{1'b0}}};
      end else begin
        rem_q <= qbit ? (rem_sh - {1'b0, sum_q}) : rem_sh;
        num_q <= {num_q[NUMW-2:0], qbit};
      end
    end
  end

  // ---------------- RK4 sequencer on one shared multiplier
  // Fifteen slots per stage: nine products give the derivative, one slot
  // forms it and adds it to the weighted sum, four products build the next
  // stage point (or the final update), and the last slot is idle.
  logic signed [31:0] x_q [4], y_q [4], k_q [4], p_q [4];
  logic signed [35:0] acc_q [4];
  logic signed [33:0] d2p_q;
  logic signed [31:0] d2_q, d3_q;
  logic signed [31:0] dv [4];
  logic [1:0] stage_q;
  logic [4:0] uop_q;
  logic [1:0] upd_j;
  logic rk_busy_q, rk_done_q;
  logic signed [31:0] ma, mb;
  logic mq;  // 1: Q8.24 by Q8.24, 0: coefficient by Q8.24
  logic signed [65:0] prod, prod_sh;
  logic signed [31:0] mres;
  logic signed [31:0] hstep;

  // Slots ten to thirteen update compartments zero to three.
  assign upd_j = uop_q[1:0] + 2'd2;

  always_comb begin
    ma = '0; mb = '0; mq = 1'b1;
    hstep = (stage_q == 2'd2) ? H_FULL : H_HALF;
    case (uop_q)
      5'd0: begin ma = y_q[2]; mb = y_q[1]; end
      5'd1: begin ma = y_q[2]; mb = y_q[3]; end
      5'd2: begin ma = y_q[2]; mb = y_q[0]; end
      5'd3: begin ma = y_q[1]; mb = y_q[3]; end
      5'd4: begin ma = {16'd0, coef_q[0]}; mb = p_q[0]; mq = 1'b0; end
      5'd5: begin ma = {16'd0, coef_q[1]}; mb = y_q[1]; mq = 1'b0; end
      5'd6: begin ma = {16'd0, coef_q[2]}; mb = p_q[1]; mq = 1'b0; end
      5'd7: begin ma = {16'd0, coef_q[3]}; mb = p_q[2]; mq = 1'b0; end
      5'd8: begin ma = {16'd0, coef_q[4]}; mb = p_q[3]; mq = 1'b0; end
      5'd10, 5'd11, 5'd12, 5'd13: begin
        ma = (stage_q == 2'd3) ? H_SIXTH : hstep;
        mb = k_q[upd_j];
      end
      default: ;
    endcase
    prod = 66'(ma) * 66'(mb);
    prod_sh = mq ? (prod >>> QSHIFT) : (prod >>> 12);
    mres = sat32(prod_sh);
  end

  // The partial G*x2*x1 + g*x1 is kept exact in d2p_q and saturated only
  // once the last term has been taken off.
  logic signed [65:0] d2_sum, d3_sum;
  assign d2_sum = 66'(d2p_q) - 66'(mres);
  assign d3_sum = 66'(d3_q) - 66'(mres);

  assign dv[2] = d2_q;
  assign dv[1] = sat32(-66'(d2_q));
  assign dv[3] = d3_q;
  assign dv[0] = sat32(-66'(d3_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rk_busy_q <= 1'b0; rk_done_q <= 1'b0; stage_q <= '0; uop_q <= '0;
    end else begin
      rk_done_q <= 1'b0;
      if (cmd_i.start_rk) begin
        rk_busy_q <= 1'b1; stage_q <= '0; uop_q <= '0;
      end else if (rk_busy_q) begin
        if (uop_q == 5'd14) begin
          uop_q <= '0;
          stage_q <= stage_q + 2'd1;
          if (stage_q == 2'd3) begin
            rk_busy_q <= 1'b0; rk_done_q <= 1'b1;
          end
        end else uop_q <= uop_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_rk) begin
      for (int i = 0; i < 4; i++) begin
        x_q[i] <= 32'(frac_q[i]) <<< FSH;
        y_q[i] <= 32'(frac_q[i]) <<< FSH;
        acc_q[i] <= '0;
      end
    end else if (rk_busy_q) begin
      case (uop_q)
        5'd0, 5'd1, 5'd2, 5'd3: p_q[uop_q[1:0]] <= mres;
        5'd4: d2p_q <= 34'(mres);
        5'd5: d2p_q <= d2p_q + 34'(mres);
        5'd6: d2_q <= sat32(d2_sum);
        5'd7: d3_q <= mres;
        5'd8: d3_q <= sat32(d3_sum);
        5'd9: begin
          for (int i = 0; i < 4; i++) begin
            if (stage_q == 2'd1 || stage_q == 2'd2)
              acc_q[i] <= acc_q[i] + (36'(dv[i]) <<< 1);
            else
              acc_q[i] <= acc_q[i] + 36'(dv[i]);
            // In the last stage k takes the weighted sum k1 + 2k2 + 2k3 + k4.
            k_q[i] <= (stage_q == 2'd3) ? sat32(66'(acc_q[i]) + 66'(dv[i])) : dv[i];
          end
        end
        5'd10, 5'd11, 5'd12, 5'd13:
          y_q[upd_j] <= sat32(66'(x_q[upd_j]) + 66'(mres));
        default: ;
      endcase
    end
  end

  // New fractions: clamp at zero, drop to Q1.FRAC_BITS, cap at start values.
  logic [FRAC_BITS:0] nf [4];
  logic [31:0] nsh [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      nsh[i] = y_q[i][31] ? 32'd0 : ($unsigned(y_q[i]) >> FSH);
      nf[i] = (i == 0 || i == 3) ? cap_r_q : cap_p_q;
      if (nsh[i] <= 32'(nf[i])) nf[i] = (FRAC_BITS+1)'(nsh[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) frac_q[i] <= '0;
      cap_r_q <= '0; cap_p_q <= '0; step_q <= '0;
      run_done_q <= 1'b0; status_q <= 1'b0;
    end else if (cmd_i.commit) begin
      if (div_done_q) begin
        run_done_q <= 1'b0;
        status_q <= zero_q;
        if (!zero_q) begin
          for (int i = 0; i < 4; i++) frac_q[i] <= quo_q[i];
          cap_r_q <= quo_q[0]; cap_p_q <= quo_q[1]; step_q <= '0;
        end
      end else begin
        status_q <= 1'b0;
        for (int i = 0; i < 4; i++) frac_q[i] <= nf[i];
        if (step_q != STEP_MAX) begin
          step_q <= step_q + 20'd1;
          run_done_q <= (step_q + 20'd1) == steps_q;
        end else run_done_q <= step_q == steps_q;
      end
    end
  end

  assign sts_o = '{div_done: div_done_q, rk_done: rk_done_q, zero_sum: zero_q};
  assign frac_o = frac_q;
  assign step_index_o = step_q;
  assign run_done_o = run_done_q;
  assign status_o = status_q;
endmodule
`default_nettype wire
